// File: src/dlagc_pkg.sv
// Shared constants, types and the log ROM builder for the dual-loop AGC gain update unit.
`default_nettype none

package dlagc_pkg;

    localparam int MAG_W       = 16;
    localparam int LOG_IN_W    = ((MAG_W > 16) ? MAG_W : 16) + 1;
    localparam int LOG_P_W     = $clog2(LOG_IN_W);
    localparam int FRAC_W      = 16;
    localparam int LOG_ENTRIES = 16;
    localparam int LOG_IDX_W   = $clog2(LOG_ENTRIES);
    localparam int LOG_W       = LOG_P_W + FRAC_W + 1;
    localparam int DLOG_W      = LOG_W + 1;
    localparam int MUL_W       = 25;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int STATE_W     = 24;
    localparam int GS_W        = 18;
    localparam int DB_SHIFT    = 24;

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [19:0] FRONT_K   = 20'd394566;
    localparam logic [19:0] AUDIO_K   = 20'd631306;
    localparam logic [6:0]  AUDIO_REF = 7'd100;
    localparam logic [16:0] COEFF_ONE = 17'd65536;

    localparam logic [3:0] SUB_LAST = 4'd11;

    localparam logic        RST_AGC_ENABLE  = 1'b1;
    localparam logic [6:0]  RST_FRONT_MAX   = 7'd64;
    localparam logic [7:0]  RST_AUDIO_BASE  = 8'd0;
    localparam logic [15:0] RST_FRONT_THR   = 16'd10000;
    localparam logic [16:0] RST_FRONT_SLOW  = 17'd699;
    localparam logic [16:0] RST_FRONT_FAST  = 17'd20972;
    localparam logic [16:0] RST_AUDIO_SLOW  = 17'd2621;
    localparam logic [16:0] RST_AUDIO_FAST  = 17'd20972;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AGC_ENABLE,
        REG_FRONT_GAIN_MAX,
        REG_AUDIO_GAIN_BASE,
        REG_FRONT_THRESHOLD,
        REG_FRONT_SLOW_COEFF,
        REG_FRONT_FAST_COEFF,
        REG_AUDIO_SLOW_COEFF,
        REG_AUDIO_FAST_COEFF
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOG_A_SETUP,
        OP_LOG_A_DONE,
        OP_LOG_B_SETUP,
        OP_DB_SETUP,
        OP_DB_DONE,
        OP_SM1,
        OP_SM2
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic loop;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic [FRAC_W:0] frac_log(input int unsigned i);
        logic [63:0]     y;
        logic [FRAC_W:0] r;
        r = '0;
        if (i >= LOG_ENTRIES) begin
            r = COEFF_ONE;
        end
        else begin
            y = (64'd1 << 30) + (64'(i) << (30 - LOG_IDX_W));
            for (int b = 15; b >= 0; b--) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    y = y >> 1;
                    r[b] = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/dlagc_ctrl.sv
// Sequencer that steps the datapath through both loops of one update.
`default_nettype none

module dlagc_ctrl import dlagc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_COMMIT
    } state_t;

    state_t     state_reg;
    logic       loop_reg;
    logic [3:0] sub_reg;
    logic       in_stall_reg;

    assign in_stall = in_stall_reg;

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.op     = OP_NOP;
        cmd.loop   = loop_reg;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                unique case (sub_reg)
                    4'd0:    cmd.op = OP_LOG_A_SETUP;
                    4'd2:    cmd.op = OP_LOG_A_DONE;
                    4'd3:    cmd.op = OP_LOG_B_SETUP;
                    4'd5:    cmd.op = OP_DB_SETUP;
                    4'd7:    cmd.op = OP_DB_DONE;
                    4'd9:    cmd.op = OP_SM1;
                    4'd11:   cmd.op = OP_SM2;
                    default: cmd.op = OP_NOP;
                endcase
            end
            ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            loop_reg     <= 1'b0;
            sub_reg      <= '0;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_RUN;
                        loop_reg     <= 1'b0;
                        sub_reg      <= '0;
                        in_stall_reg <= 1'b1;
                    end
                end
                ST_RUN:
                begin
                    if (sub_reg == SUB_LAST)
                    begin
                        sub_reg <= '0;
                        if (loop_reg)
                        begin
                            state_reg <= ST_COMMIT;
                        end
                        else
                        begin
                            loop_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 4'd1;
                    end
                end
                ST_COMMIT:
                begin
                    if (status.out_free)
                    begin
                        state_reg    <= ST_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/dlagc_datapath.sv
// Config registers, log unit, shared multiplier, filters and gain state of the AGC.
`default_nettype none

module dlagc_datapath import dlagc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [MAG_W-1:0]     peak_magnitude,
    input  wire logic [MAG_W-1:0]     audio_magnitude,
    input  wire logic                 in_receive,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [6:0]                front_gain,
    output logic                      front_gain_write,
    output logic signed [7:0]         audio_level,
    output logic                      audio_level_write
);

    logic               agc_enable_reg;
    logic [6:0]         front_gain_max_reg;
    logic signed [7:0]  audio_gain_base_reg;
    logic [15:0]        front_threshold_reg;
    logic [16:0]        front_slow_reg;
    logic [16:0]        front_fast_reg;
    logic [16:0]        audio_slow_reg;
    logic [16:0]        audio_fast_reg;

    logic [MAG_W-1:0]   peak_reg;
    logic [MAG_W-1:0]   aud_reg;
    logic               rx_reg;

    logic signed [MUL_W-1:0]   mul_a_reg;
    logic signed [MUL_W-1:0]   mul_b_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic [LOG_W-1:0]          base_reg;
    logic [LOG_W-1:0]          la_reg;
    logic [16:0]               c_reg;

    logic signed [STATE_W-1:0] front_filt_reg;
    logic signed [STATE_W-1:0] audio_filt_reg;
    logic signed [STATE_W-1:0] af_reg;
    logic [6:0]                front_gain_now_reg;
    logic [6:0]                front_last_reg;
    logic [6:0]                front_max_applied_reg;
    logic                      front_max_valid_reg;
    logic signed [7:0]         audio_level_now_reg;
    logic signed [7:0]         audio_last_reg;
    logic signed [7:0]         audio_base_applied_reg;
    logic                      audio_base_valid_reg;
    logic                      out_valid_reg;
    logic                      fwr_reg;
    logic                      awr_reg;

    logic [FRAC_W:0] log_rom [LOG_ENTRIES+1];

    for (genvar g = 0; g <= LOG_ENTRIES; g++)
    begin : g_rom
        assign log_rom[g] = frac_log(g);
    end

    function automatic logic signed [15:0] trunc_q8(input logic signed [STATE_W-1:0] v);
        logic [STATE_W-1:0] mag;
        logic [15:0]        q;
        mag = v[STATE_W-1] ? (~v + STATE_W'(1)) : v;
        q   = mag[23:8];
        return v[STATE_W-1] ? $signed(~q + 16'd1) : $signed(q);
    endfunction

    logic [15:0]              thr_eff;
    logic [LOG_IN_W-1:0]      log_x;
    logic [LOG_P_W-1:0]       log_p;
    logic [LOG_IN_W+FRAC_W-1:0] log_norm;
    logic [FRAC_W-1:0]        log_f;
    logic [LOG_IDX_W:0]       idx_lo;
    logic [LOG_IDX_W:0]       idx_hi;
    logic [FRAC_W-1:0]        log_rem;
    logic [FRAC_W:0]          rom_lo;
    logic [FRAC_W:0]          rom_hi;
    logic [FRAC_W:0]          rom_diff;
    logic [LOG_W-1:0]         log_base;
    logic [LOG_W-1:0]         log_done;
    logic signed [DLOG_W-1:0] dlog;
    logic [19:0]              db_k;
    logic signed [PROD_W-1:0] db_sum;
    logic signed [PROD_W-1:0] db_v;
    logic signed [15:0]       e_calc;
    logic [16:0]              c_raw;
    logic [16:0]              c_sat;
    logic signed [STATE_W-1:0] old_filt;
    logic signed [SUM_W-1:0]  sm_sum;
    logic signed [SUM_W-1:0]  sm_sh;
    logic signed [STATE_W-1:0] filt;

    always_comb
    begin
        thr_eff = (front_threshold_reg == 16'd0) ? 16'd1 : front_threshold_reg;
        if (cmd.op == OP_LOG_B_SETUP)
        begin
            log_x = cmd.loop ? (LOG_IN_W'(aud_reg) + LOG_IN_W'(1))
                             : (LOG_IN_W'(peak_reg) + LOG_IN_W'(1));
        end
        else
        begin
            log_x = cmd.loop ? LOG_IN_W'(AUDIO_REF) : LOG_IN_W'(thr_eff);
        end
        log_p = '0;
        for (int i = 0; i < LOG_IN_W; i++)
        begin
            if (log_x[i])
            begin
                log_p = LOG_P_W'(i);
            end
        end
        log_norm = {log_x, {FRAC_W{1'b0}}} >> log_p;
        log_f    = log_norm[FRAC_W-1:0];
        idx_lo   = {1'b0, log_f[FRAC_W-1 -: LOG_IDX_W]};
        idx_hi   = idx_lo + (LOG_IDX_W+1)'(1);
        log_rem  = {log_f[FRAC_W-LOG_IDX_W-1:0], {LOG_IDX_W{1'b0}}};
        rom_lo   = log_rom[idx_lo];
        rom_hi   = log_rom[idx_hi];
        rom_diff = rom_hi - rom_lo;
        log_base = (LOG_W'(log_p) << FRAC_W) + LOG_W'(rom_lo);

        log_done = base_reg + LOG_W'(prod_reg[2*FRAC_W:FRAC_W]);
        dlog     = $signed({1'b0, la_reg}) - $signed({1'b0, log_done});
        db_k     = cmd.loop ? AUDIO_K : FRONT_K;

        db_sum = prod_reg + PROD_W'(1 << (DB_SHIFT - 1));
        db_v   = db_sum >>> DB_SHIFT;
        if (db_v > PROD_W'(32767))
        begin
            e_calc = 16'sd32767;
        end
        else if (db_v < PROD_W'(-32768))
        begin
            e_calc = -16'sd32768;
        end
        else
        begin
            e_calc = db_v[15:0];
        end

        if (cmd.loop)
        begin
            c_raw = (e_calc > 16'sd0) ? audio_slow_reg : audio_fast_reg;
        end
        else
        begin
            c_raw = (e_calc > 16'sd0) ? front_slow_reg : front_fast_reg;
        end
        c_sat = (c_raw > COEFF_ONE) ? COEFF_ONE : c_raw;

        old_filt = cmd.loop ? audio_filt_reg : front_filt_reg;
        sm_sum   = SUM_W'(acc_reg) + SUM_W'(prod_reg) + SUM_W'(32768);
        sm_sh    = sm_sum >>> FRAC_W;
        filt     = sm_sh[STATE_W-1:0];
    end

    logic signed [15:0]     front_step;
    logic signed [15:0]     audio_step;
    logic signed [GS_W-1:0] g_sum;
    logic signed [GS_W-1:0] s_sum;
    logic [6:0]             g_next;
    logic signed [7:0]      s_next;
    logic                   front_apply;
    logic                   audio_apply;

    always_comb
    begin
        front_step = trunc_q8(front_filt_reg);
        audio_step = trunc_q8(af_reg);
        g_sum = $signed(GS_W'(front_gain_now_reg)) + GS_W'(front_step);
        if (g_sum < 0)
        begin
            g_next = 7'd0;
        end
        else if (g_sum > $signed(GS_W'(front_gain_max_reg)))
        begin
            g_next = front_gain_max_reg;
        end
        else
        begin
            g_next = g_sum[6:0];
        end
        s_sum = GS_W'(audio_gain_base_reg) + GS_W'(audio_step);
        if (s_sum > GS_W'(127))
        begin
            s_next = 8'sd127;
        end
        else if (s_sum < GS_W'(-128))
        begin
            s_next = -8'sd128;
        end
        else
        begin
            s_next = s_sum[7:0];
        end
        front_apply = (!front_max_valid_reg || front_max_applied_reg != front_gain_max_reg)
                      && rx_reg;
        audio_apply = (!audio_base_valid_reg || audio_base_applied_reg != audio_gain_base_reg)
                      && rx_reg;
    end

    assign status.out_free   = !out_valid_reg || !out_stall;
    assign out_valid         = out_valid_reg;
    assign front_gain        = front_gain_now_reg;
    assign front_gain_write  = fwr_reg;
    assign audio_level       = audio_level_now_reg;
    assign audio_level_write = awr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agc_enable_reg      <= RST_AGC_ENABLE;
            front_gain_max_reg  <= RST_FRONT_MAX;
            audio_gain_base_reg <= RST_AUDIO_BASE;
            front_threshold_reg <= RST_FRONT_THR;
            front_slow_reg      <= RST_FRONT_SLOW;
            front_fast_reg      <= RST_FRONT_FAST;
            audio_slow_reg      <= RST_AUDIO_SLOW;
            audio_fast_reg      <= RST_AUDIO_FAST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AGC_ENABLE:       agc_enable_reg      <= cfg_data[0];
                REG_FRONT_GAIN_MAX:   front_gain_max_reg  <= cfg_data[6:0];
                REG_AUDIO_GAIN_BASE:  audio_gain_base_reg <= cfg_data[7:0];
                REG_FRONT_THRESHOLD:  front_threshold_reg <= cfg_data[15:0];
                REG_FRONT_SLOW_COEFF: front_slow_reg      <= cfg_data;
                REG_FRONT_FAST_COEFF: front_fast_reg      <= cfg_data;
                REG_AUDIO_SLOW_COEFF: audio_slow_reg      <= cfg_data;
                REG_AUDIO_FAST_COEFF: audio_fast_reg      <= cfg_data;
                default:              agc_enable_reg      <= agc_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a_reg * mul_b_reg;
        if (cmd.load)
        begin
            peak_reg <= peak_magnitude;
            aud_reg  <= audio_magnitude;
            rx_reg   <= in_receive;
        end
        unique case (cmd.op)
            OP_LOG_A_SETUP, OP_LOG_B_SETUP:
            begin
                mul_a_reg <= MUL_W'(rom_diff);
                mul_b_reg <= MUL_W'(log_rem);
                base_reg  <= log_base;
            end
            OP_LOG_A_DONE:
            begin
                la_reg <= log_done;
            end
            OP_DB_SETUP:
            begin
                mul_a_reg <= MUL_W'(dlog);
                mul_b_reg <= MUL_W'(db_k);
            end
            OP_DB_DONE:
            begin
                c_reg     <= c_sat;
                mul_a_reg <= MUL_W'(c_sat);
                mul_b_reg <= MUL_W'(e_calc);
            end
            OP_SM1:
            begin
                acc_reg   <= prod_reg;
                mul_a_reg <= MUL_W'(COEFF_ONE - c_reg);
                mul_b_reg <= MUL_W'(old_filt);
            end
            OP_SM2:
            begin
                if (cmd.loop)
                begin
                    af_reg <= filt;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_filt_reg         <= '0;
            audio_filt_reg         <= '0;
            front_gain_now_reg     <= RST_FRONT_MAX;
            front_last_reg         <= RST_FRONT_MAX;
            front_max_applied_reg  <= '0;
            front_max_valid_reg    <= 1'b0;
            audio_level_now_reg    <= RST_AUDIO_BASE;
            audio_last_reg         <= RST_AUDIO_BASE;
            audio_base_applied_reg <= '0;
            audio_base_valid_reg   <= 1'b0;
            out_valid_reg          <= 1'b0;
            fwr_reg                <= 1'b0;
            awr_reg                <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_SM2 && !cmd.loop)
            begin
                front_filt_reg <= filt;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                fwr_reg       <= agc_enable_reg ? (g_next != front_last_reg) : front_apply;
                awr_reg       <= agc_enable_reg ? (s_next != audio_last_reg) : audio_apply;
                if (agc_enable_reg)
                begin
                    front_gain_now_reg <= g_next;
                    if (g_next != front_last_reg)
                    begin
                        front_last_reg <= g_next;
                    end
                    audio_filt_reg      <= af_reg;
                    audio_level_now_reg <= s_next;
                    if (s_next != audio_last_reg)
                    begin
                        audio_last_reg <= s_next;
                    end
                end
                else
                begin
                    if (front_apply)
                    begin
                        front_gain_now_reg    <= front_gain_max_reg;
                        front_max_applied_reg <= front_gain_max_reg;
                        front_max_valid_reg   <= 1'b1;
                    end
                    if (audio_apply)
                    begin
                        audio_level_now_reg    <= audio_gain_base_reg;
                        audio_base_applied_reg <= audio_gain_base_reg;
                        audio_base_valid_reg   <= 1'b1;
                    end
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/dual_loop_agc_gain_update_unit.sv
// Top level of the dual-loop AGC gain update unit.
// Input channel: one word per audio block (peak_magnitude, audio_magnitude,
// in_receive), taken when in_valid is high and in_stall low.
// Output channel: one word per input word (front_gain, front_gain_write,
// audio_level, audio_level_write), taken when out_valid is high and
// out_stall low.
// Config port: cfg_write_en, cfg_index, cfg_data; write only while idle.
// One word runs from accept to out_valid as two passes of 12
// sequencer steps through the shared log unit and the single 25x25
// multiplier, then a commit step that waits until the output is free.
// A new word can be accepted from the cycle after the commit.
// in_stall is high from accept until commit. A finished word waits in the
// output register while out_stall is high; the next word is accepted and
// computed meanwhile, and holds in its commit step until the output frees.
// Reset clears both filters, loads the register defaults, sets the front
// gain to its default ceiling and forces the first fixed apply.
`default_nettype none

module dual_loop_agc_gain_update_unit import dlagc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [MAG_W-1:0]     peak_magnitude,
    input  wire logic [MAG_W-1:0]     audio_magnitude,
    input  wire logic                 in_receive,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [6:0]                front_gain,
    output logic                      front_gain_write,
    output logic signed [7:0]         audio_level,
    output logic                      audio_level_write
);

    cmd_t    cmd;
    status_t status;

    dlagc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dlagc_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .peak_magnitude    (peak_magnitude),
        .audio_magnitude   (audio_magnitude),
        .in_receive        (in_receive),
        .cmd               (cmd),
        .status            (status),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .front_gain        (front_gain),
        .front_gain_write  (front_gain_write),
        .audio_level       (audio_level),
        .audio_level_write (audio_level_write)
    );

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted a second word while one is in flight");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while output register is occupied");

    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_valid && !in_stall))
        else $error("commit did not present a word and release input");

endmodule

`default_nettype wire
